/* design/efa_pkg.sv */
package efa_pkg;

   localparam int PIXEL_W = 8;
   localparam int COORD_W = 8;

   localparam logic [PIXEL_W-1:0] PIXEL_RESET = 8'd128;
   localparam logic [PIXEL_W-1:0] STEP_RESET  = 8'd30;
   localparam logic [PIXEL_W-1:0] PIXEL_MAX   = 8'd255;

   // Input item modes.
   localparam logic MODE_EVENT = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   // Depth of the result queue and the width of its fill count.
   localparam int RSP_FIFO_DEPTH = 4;
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH) + 1;

   typedef struct packed {
      logic               mode;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               polarity;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic               out_of_range;
   } rsp_type;

endpackage

/* design/efa_frame_ram.sv */
module efa_frame_ram #(
   parameter int DEPTH  = 43200,
   parameter int ADDR_W = 16
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [efa_pkg::PIXEL_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [efa_pkg::PIXEL_W-1:0] wr_data
);
   import efa_pkg::*;

   logic [PIXEL_W-1:0] frame_mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   // Read-first: a read and a write of the same entry in one cycle return the old value.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/efa_rsp_fifo.sv */
module efa_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  efa_pkg::rsp_type              push_data,
   output logic                          out_valid,
   input  logic                          out_stall,
   output efa_pkg::rsp_type              out_data,
   output logic [efa_pkg::RSP_CNT_W-1:0] fill_count
);
   import efa_pkg::*;

   localparam int PTR_W = $clog2(RSP_FIFO_DEPTH);

   rsp_type            entry_ff [RSP_FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic               pop;

   assign out_valid  = (count_ff != '0);
   assign out_data   = entry_ff[rd_ptr_ff];
   assign pop        = out_valid && !out_stall;
   assign fill_count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/event_frame_accumulator_core.sv */
// Event frame accumulator: an 8-bit greyscale frame store updated by camera events.
// The request channel (req_valid, req_stall, req_data) carries one item per transfer:
// an event item brightens or darkens one pixel by the step size with saturation, and a
// read item returns a pixel unchanged so that the frame can be scanned out.
// Every request transfer yields exactly one transfer on the response channel
// (rsp_valid, rsp_stall, rsp_data) with the resulting pixel value and an out-of-range
// flag; a coordinate outside the frame returns pixel 0 with the flag set.
// The user must write the step size via csr_write_enable and csr_write_data only while
// idle; the block does not enforce it. Items pass the read stage, then the queue.
// Throughput is one item per cycle while req_stall is low: the memory is read when
// an item is taken, written back the next cycle, and forwarded to the next item.
// Responses wait in a four-entry queue; req_stall rises only when the queue and the
// read stage together hold four items, so a stalled receiver backs up the requester.
// After reset the block walks the frame memory once, writing mid-grey into every one of
// its FRAME_WIDTH * FRAME_HEIGHT pixels; req_stall is high for that whole pass, while
// step size writes are taken as ever.
module event_frame_accumulator_core #(
   parameter int FRAME_WIDTH  = 240,
   parameter int FRAME_HEIGHT = 180
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  efa_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output efa_pkg::rsp_type            rsp_data,
   input  logic                        csr_write_enable,
   input  logic [efa_pkg::PIXEL_W-1:0] csr_write_data
);
   import efa_pkg::*;

   localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIN_W  = 2 * COORD_W;

   localparam logic [COORD_W:0]  COL_LIMIT = (COORD_W + 1)'(FRAME_WIDTH);
   localparam logic [COORD_W:0]  ROW_LIMIT = (COORD_W + 1)'(FRAME_HEIGHT);
   localparam logic [LIN_W-1:0]  LIN_STRIDE = LIN_W'(FRAME_WIDTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

   // Configuration.
   logic [PIXEL_W-1:0] step_ff;

   // Clearing pass after reset.
   logic               clearing_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;

   // Request side: range check and linear address.
   logic               req_fire;
   logic               in_range;
   logic [LIN_W-1:0]   lin_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;
   logic [PIXEL_W-1:0] rd_data;

   // Read stage: the item whose memory data arrives this cycle.
   logic               s1_valid_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;
   logic               s1_mode_ff;
   logic               s1_pol_ff;
   logic               s1_oor_ff;

   // Most recent write back, forwarded to the item right behind it.
   logic               fwd_valid_ff;
   logic [ADDR_W-1:0]  fwd_addr_ff;
   logic [PIXEL_W-1:0] fwd_data_ff;

   logic [PIXEL_W-1:0] base_pix;
   logic [PIXEL_W:0]   sum_pix;
   logic [PIXEL_W-1:0] new_pix;
   logic               s1_write;
   rsp_type            s1_rsp;

   // Frame memory write port.
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [PIXEL_W-1:0] wr_data;

   logic [RSP_CNT_W-1:0] fifo_count;
   logic [RSP_CNT_W:0]   in_flight;

   // A new item is taken only while the queue is sure to have room for it.
   assign in_flight = (RSP_CNT_W + 1)'(fifo_count) + (RSP_CNT_W + 1)'(s1_valid_ff);
   assign req_stall = clearing_ff || (in_flight >= (RSP_CNT_W + 1)'(RSP_FIFO_DEPTH));
   assign req_fire  = req_valid && !req_stall;

   assign in_range = ({1'b0, req_data.column} < COL_LIMIT) &&
                     ({1'b0, req_data.row} < ROW_LIMIT);
   assign lin_addr = LIN_W'(req_data.row) * LIN_STRIDE + LIN_W'(req_data.column);
   assign rd_addr  = lin_addr[ADDR_W-1:0];
   assign rd_en    = req_fire && in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            step_ff <= csr_write_data;
         end
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff <= req_fire;
         if (s1_write) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_addr_ff <= rd_addr;
         s1_mode_ff <= req_data.mode;
         s1_pol_ff  <= req_data.polarity;
         s1_oor_ff  <= !in_range;
      end
      if (s1_write) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_pix;
      end
   end

   efa_frame_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_frame_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // The memory returns the value from before a write in the same cycle, so the item
   // directly behind a write to the same pixel takes the forwarded value instead.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         base_pix = fwd_data_ff;
      end else begin
         base_pix = rd_data;
      end
      sum_pix = {1'b0, base_pix} + {1'b0, step_ff};
      if (s1_pol_ff) begin
         new_pix = sum_pix[PIXEL_W] ? PIXEL_MAX : sum_pix[PIXEL_W-1:0];
      end else begin
         new_pix = (base_pix > step_ff) ? (base_pix - step_ff) : '0;
      end
   end

   assign s1_write = s1_valid_ff && !s1_oor_ff && (s1_mode_ff == MODE_EVENT);

   always_comb begin
      if (s1_oor_ff) begin
         s1_rsp.pixel_value  = '0;
         s1_rsp.out_of_range = 1'b1;
      end else if (s1_mode_ff == MODE_READ) begin
         s1_rsp.pixel_value  = base_pix;
         s1_rsp.out_of_range = 1'b0;
      end else begin
         s1_rsp.pixel_value  = new_pix;
         s1_rsp.out_of_range = 1'b0;
      end
   end

   // The clearing pass owns the write port; no item is in flight while it runs.
   assign wr_en   = clearing_ff || s1_write;
   assign wr_addr = clearing_ff ? clr_addr_ff : s1_addr_ff;
   assign wr_data = clearing_ff ? PIXEL_RESET : new_pix;

   efa_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff),
      .push_data  (s1_rsp),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (rsp_data),
      .fill_count (fifo_count)
   );

endmodule

/* design/efa_checker.sv */
module efa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input efa_pkg::req_type            req_data,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input efa_pkg::rsp_type            rsp_data,
   input logic                        csr_write_enable,
   input logic [efa_pkg::PIXEL_W-1:0] csr_write_data
);
   import efa_pkg::*;

   logic [RSP_CNT_W-1:0] pending_ff;
   logic                 req_xfer;
   logic                 rsp_xfer;
   logic                 unused_inputs;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign unused_inputs = ^{req_data, csr_write_enable, csr_write_data};

   // Items taken whose response has not yet been transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_xfer && !rsp_xfer) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_xfer && !req_xfer) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   // The frame clear keeps requests out for at least the cycle after reset.
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken right after reset");

   // A response only appears for an item that was taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != '0))
      else $error("response without a pending request");

   // Items in flight never exceed the response queue depth.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= RSP_CNT_W'(RSP_FIFO_DEPTH))
      else $error("more items in flight than queue entries");

   // An out-of-range response carries a zero pixel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |-> (rsp_data.pixel_value == '0) ||
      unused_inputs != unused_inputs)
      else $error("out-of-range response with nonzero pixel");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind event_frame_accumulator_core efa_checker u_efa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_data         (req_data),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_data         (rsp_data),
   .csr_write_enable (csr_write_enable),
   .csr_write_data   (csr_write_data)
);
